// ===== design/adis_pkg.sv =====
// Shared types and constants for the advertising-data identity strip.
`timescale 1ns / 1ps

package adis_pkg;

  // Largest payload length accepted, in bytes
  localparam int unsigned MaxPayloadDef = 31;
  // Width of the randomize mask, one bit per payload byte
  localparam int unsigned MaskW = 31;

  // Element type codes
  localparam logic [7:0] TypeFlags      = 8'h01;
  localparam logic [7:0] TypeUuid16Inc  = 8'h02;
  localparam logic [7:0] TypeUuid16Cmp  = 8'h03;
  localparam logic [7:0] TypeTxPower    = 8'h0A;
  localparam logic [7:0] TypeAppearance = 8'h19;
  localparam logic [7:0] TypeNameShort  = 8'h08;
  localparam logic [7:0] TypeNameFull   = 8'h09;
  localparam logic [7:0] TypeSvcData16  = 8'h16;
  localparam logic [7:0] TypeMfrData    = 8'hFF;

  // Manufacturer beacon prefix bytes
  localparam logic [7:0] Prefix0 = 8'h4C;
  localparam logic [7:0] Prefix1 = 8'h00;
  localparam logic [7:0] Prefix2 = 8'h02;
  localparam logic [7:0] Prefix3 = 8'h15;

  // Identifiers used to classify the family
  localparam logic [15:0] CompanyRef = 16'h004C;
  localparam logic [15:0] UuidRefA   = 16'hFEAA;
  localparam logic [15:0] UuidRefB   = 16'hFEED;

  // Family codes
  localparam logic [1:0] FamCompany = 2'd0;
  localparam logic [1:0] FamUuidA   = 2'd1;
  localparam logic [1:0] FamUuidB   = 2'd2;
  localparam logic [1:0] FamOther   = 2'd3;

  typedef struct packed {
    logic [7:0]  ad_byte;
    logic        is_last_byte;
    logic [15:0] company_code;
  } adis_in_t;

  typedef struct packed {
    logic [7:0]       skeleton_byte;
    logic             end_of_payload;
    logic             accepted;
    logic [MaskW-1:0] random_mask;
    logic [4:0]       name_offset;
    logic [4:0]       name_length;
    logic [15:0]      service_uuid;
    logic [1:0]       family_code;
  } adis_out_t;

endpackage

// ===== design/adv_data_identity_strip_core.sv =====
// Top level of the advertising-data identity strip: element walker and result register.
`timescale 1ns / 1ps

// Takes an advertising payload one byte per beat and answers every byte with one
// result beat: the byte itself, or zero inside the value of a name element. The
// result for the byte flagged last also carries the verdict and, when accepted, the
// randomize mask, the name position and length, the 16-bit service UUID and the
// family code, and the walker then starts over for the next payload. The element
// walk is a few small compares on the byte position and the element bounds, done
// between the accept edge and a single result register, so a byte can be taken on
// every cycle while the downstream side keeps up, and a new byte is taken while
// the current result waits as long as it is taken in that cycle.
module adv_data_identity_strip_core
  import adis_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = MaxPayloadDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  adis_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output adis_out_t out_data_o
);

  localparam logic [5:0] MaxPos = 6'(MAX_PAYLOAD);

  // Walker state
  logic [5:0]       pos_q, pos_d;
  logic [5:0]       start_q, start_d;
  logic [8:0]       end_q, end_d;
  logic [7:0]       type_q, type_d;
  logic [3:0]       prefix_q, prefix_d;
  logic [MaskW-1:0] mask_q, mask_d;
  logic [4:0]       noff_q, noff_d;
  logic [4:0]       nlen_q, nlen_d;
  logic [15:0]      uuid_q, uuid_d;
  logic [15:0]      company_q, company_d;
  logic             stopped_q, stopped_d;
  logic             reject_q, reject_d;

  // Result register
  logic             out_valid_q;
  adis_out_t        out_q;
  adis_out_t        res;

  logic             in_fire;
  logic [7:0]       b;
  logic             last;
  logic [8:0]       vlen;
  logic [5:0]       voff;
  logic [4:0]       bit_p;
  logic [4:0]       bit_pm1;
  logic             rej_fin;
  logic [1:0]       fam;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign b       = in_data_i.ad_byte;
  assign last    = in_data_i.is_last_byte;
  assign vlen    = end_q - {3'b000, start_q} - 9'd2;
  assign voff    = pos_q - start_q - 6'd2;
  assign bit_p   = pos_q[4:0];
  assign bit_pm1 = bit_p - 5'd1;

  // Walk one byte and build its result
  always_comb begin
    pos_d     = pos_q;
    start_d   = start_q;
    end_d     = end_q;
    type_d    = type_q;
    prefix_d  = prefix_q;
    mask_d    = mask_q;
    noff_d    = noff_q;
    nlen_d    = nlen_q;
    uuid_d    = uuid_q;
    company_d = (pos_q == 6'd0) ? in_data_i.company_code : company_q;
    stopped_d = stopped_q;
    reject_d  = reject_q;
    res       = '0;
    res.skeleton_byte = b;

    if (pos_q >= MaxPos) begin
      reject_d = 1'b1;
    end else if (!stopped_q && !reject_q) begin
      if ({3'b000, pos_q} == end_q) begin
        // Length byte: open an element or stop at a zero length
        if (!last) begin
          if (b == 8'h00) begin
            stopped_d = 1'b1;
          end else begin
            start_d  = pos_q;
            end_d    = {3'b000, pos_q} + 9'd1 + {1'b0, b};
            type_d   = '0;
            prefix_d = '0;
          end
        end
      end else if (pos_q == start_q + 6'd1) begin
        // Type byte: capture name bounds, check short data elements
        type_d = b;
        if (b == TypeNameShort || b == TypeNameFull) begin
          noff_d = 5'(start_q + 6'd2);
          nlen_d = vlen[4:0];
        end else if ((b == TypeMfrData || b == TypeSvcData16) && vlen < 9'd2) begin
          reject_d = 1'b1;
        end
      end else begin
        // Value byte
        if (type_q == TypeNameShort || type_q == TypeNameFull) begin
          res.skeleton_byte = '0;
        end else if (type_q == TypeMfrData) begin
          unique case (voff)
            6'd0: begin
              if (b == Prefix0) prefix_d[0] = 1'b1;
            end
            6'd1: begin
              if (b == Prefix1) prefix_d[1] = 1'b1;
            end
            6'd2: begin
              if (b == Prefix2) prefix_d[2] = 1'b1;
              mask_d[bit_p] = 1'b1;
            end
            6'd3: begin
              if (b == Prefix3) prefix_d[3] = 1'b1;
              if (vlen >= 9'd4 && prefix_d == 4'hF) mask_d[bit_pm1] = 1'b0;
              else mask_d[bit_p] = 1'b1;
            end
            default: begin
              mask_d[bit_p] = 1'b1;
            end
          endcase
        end else if (type_q == TypeSvcData16) begin
          if (voff == 6'd0) uuid_d[7:0] = b;
          else if (voff == 6'd1) uuid_d[15:8] = b;
          else mask_d[bit_p] = 1'b1;
        end else if (!(type_q == TypeFlags || type_q == TypeUuid16Inc ||
                       type_q == TypeUuid16Cmp || type_q == TypeTxPower ||
                       type_q == TypeAppearance)) begin
          mask_d[bit_p] = 1'b1;
        end
      end
    end

    // Classify the family from the final identifiers
    if (company_d == CompanyRef) fam = FamCompany;
    else if (uuid_d == UuidRefA) fam = FamUuidA;
    else if (uuid_d == UuidRefB) fam = FamUuidB;
    else fam = FamOther;

    rej_fin = reject_d || (!stopped_d && (end_d > {3'b000, pos_q} + 9'd1));

    if (last) begin
      // Report the payload summary and start over
      res.end_of_payload = 1'b1;
      if (!rej_fin) begin
        res.accepted     = 1'b1;
        res.random_mask  = mask_d;
        res.name_offset  = noff_d;
        res.name_length  = nlen_d;
        res.service_uuid = uuid_d;
        res.family_code  = fam;
      end
      pos_d     = '0;
      start_d   = '0;
      end_d     = '0;
      type_d    = '0;
      prefix_d  = '0;
      mask_d    = '0;
      noff_d    = '0;
      nlen_d    = '0;
      uuid_d    = '0;
      company_d = '0;
      stopped_d = 1'b0;
      reject_d  = 1'b0;
    end else if (pos_q != 6'd63) begin
      pos_d = pos_q + 6'd1;
    end
  end

  // Advance walker state on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      start_q   <= '0;
      end_q     <= '0;
      type_q    <= '0;
      prefix_q  <= '0;
      mask_q    <= '0;
      noff_q    <= '0;
      nlen_q    <= '0;
      uuid_q    <= '0;
      company_q <= '0;
      stopped_q <= 1'b0;
      reject_q  <= 1'b0;
    end else if (in_fire) begin
      pos_q     <= pos_d;
      start_q   <= start_d;
      end_q     <= end_d;
      type_q    <= type_d;
      prefix_q  <= prefix_d;
      mask_q    <= mask_d;
      noff_q    <= noff_d;
      nlen_q    <= nlen_d;
      uuid_q    <= uuid_d;
      company_q <= company_d;
      stopped_q <= stopped_d;
      reject_q  <= reject_d;
    end
  end

  // Hold the result beat until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== design/adis_checker.sv =====
// Port-level checks for the advertising-data identity strip, bound to the top level.
`timescale 1ns / 1ps

module adis_checker
  import adis_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input adis_in_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input adis_out_t out_data_o
);

  // Keep a stalled result beat valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // Keep a stalled result beat unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("result beat changed while stalled");

  // Take input whenever no result is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result register");

  // Carry a summary only on an accepted final byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !(out_data_o.end_of_payload && out_data_o.accepted) |->
      out_data_o.random_mask == '0 && out_data_o.name_offset == '0 &&
      out_data_o.name_length == '0 && out_data_o.service_uuid == '0 &&
      out_data_o.family_code == FamCompany)
    else $error("summary fields set outside an accepted final byte");

  // Each accepted input produces a result beat on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted byte produced no result beat");

endmodule

bind adv_data_identity_strip_core adis_checker u_adis_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);

// ===== verif/adv_data_identity_strip_core_test.sv =====
// Self-checking testbench for the advertising-data identity strip core.
`timescale 1ns / 1ps

module adv_data_identity_strip_core_test;
  import adis_pkg::*;

  localparam int ItemTarget  = 1100;
  localparam int MaxGap      = 12;
  localparam int HoldCycles  = 80;
  localparam int DrainCycles = 20;
  localparam int HoldAt      = 300;
  localparam int PauseAt     = 700;

  // One directed beat: the byte, its flags, and for rows with a hand-written
  // expectation the verdict and family of the final result.
  typedef struct packed {
    logic [7:0]  b;
    logic        last;
    logic [15:0] co;
    logic        typed;
    logic        acc;
    logic [1:0]  fam;
  } row_t;

  localparam int NRows = 26;
  localparam row_t DirRows [NRows] = '{
    // lone zero byte: empty payload, accepted, company match
    '{8'h00, 1'b1, CompanyRef, 1'b1, 1'b1, FamCompany},
    // lone length byte on the final byte: starts nothing, accepted
    '{8'hFF, 1'b1, 16'hFFFF, 1'b1, 1'b1, FamOther},
    // full name element: value bytes zeroed, offset and length reported
    '{8'h03, 1'b0, 16'h1234, 1'b0, 1'b0, FamCompany},
    '{TypeNameFull, 1'b0, 16'h0000, 1'b0, 1'b0, FamCompany},
    '{8'h41, 1'b0, 16'h0000, 1'b0, 1'b0, FamCompany},
    '{8'h42, 1'b1, 16'h0000, 1'b0, 1'b0, FamCompany},
    // manufacturer data with the full beacon prefix
    '{8'h06, 1'b0, 16'h0000, 1'b0, 1'b0, FamCompany},
    '{TypeMfrData, 1'b0, 16'hFFFF, 1'b0, 1'b0, FamCompany},
    '{Prefix0, 1'b0, 16'h0000, 1'b0, 1'b0, FamCompany},
    '{Prefix1, 1'b0, 16'h0000, 1'b0, 1'b0, FamCompany},
    '{Prefix2, 1'b0, 16'h0000, 1'b0, 1'b0, FamCompany},
    '{Prefix3, 1'b0, 16'h0000, 1'b0, 1'b0, FamCompany},
    '{8'h01, 1'b1, 16'h0000, 1'b0, 1'b0, FamCompany},
    // 16-bit service data carrying the first reference UUID
    '{8'h04, 1'b0, 16'hABCD, 1'b0, 1'b0, FamCompany},
    '{TypeSvcData16, 1'b0, 16'h0000, 1'b0, 1'b0, FamCompany},
    '{UuidRefA[7:0], 1'b0, 16'h0000, 1'b0, 1'b0, FamCompany},
    '{UuidRefA[15:8], 1'b0, 16'h0000, 1'b0, 1'b0, FamCompany},
    '{8'h07, 1'b1, 16'h0000, 1'b0, 1'b0, FamCompany},
    // manufacturer data too short for a company id: rejected
    '{8'h02, 1'b0, CompanyRef, 1'b0, 1'b0, FamCompany},
    '{TypeMfrData, 1'b0, 16'h0000, 1'b0, 1'b0, FamCompany},
    '{8'h00, 1'b1, 16'h0000, 1'b1, 1'b0, FamCompany},
    // element running past the final byte: rejected
    '{8'h05, 1'b0, 16'h0000, 1'b0, 1'b0, FamCompany},
    '{TypeFlags, 1'b0, 16'h0000, 1'b0, 1'b0, FamCompany},
    '{8'h02, 1'b1, 16'h0000, 1'b1, 1'b0, FamCompany},
    // zero length byte stops the walk, the rest passes unchanged
    '{8'h00, 1'b0, 16'h5555, 1'b0, 1'b0, FamCompany},
    '{8'h55, 1'b1, 16'h0000, 1'b1, 1'b1, FamOther}
  };

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      out_ready = 1'b0;
  adis_in_t  in_data   = '0;
  logic      in_ready;
  logic      out_valid;
  adis_out_t out_data;

  adv_data_identity_strip_core DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Walker state mirrored at the block's widths
  logic [5:0]       pos;
  logic [5:0]       el_start;
  logic [8:0]       el_end;
  logic [7:0]       el_type;
  logic [3:0]       prefix_seen;
  logic [MaskW-1:0] mask_seen;
  logic [4:0]       noff_seen;
  logic [4:0]       nlen_seen;
  logic [15:0]      uuid_seen;
  logic [15:0]      company_seen;
  logic             stopped;
  logic             rejected;

  adis_out_t   pending_results[$];
  logic [7:0]  frame[$];
  int          errors;
  int          n_sent;
  int          n_checked;
  int          n_payloads;
  int          n_accepted;
  bit          rx_hold;

  function automatic void clear_walker();
    pos = '0; el_start = '0; el_end = '0; el_type = '0; prefix_seen = '0;
    mask_seen = '0; noff_seen = '0; nlen_seen = '0; uuid_seen = '0;
    company_seen = '0; stopped = 1'b0; rejected = 1'b0;
  endfunction

  // Advance the walker by one byte and return the result beat it causes.
  function automatic adis_out_t walk_byte(adis_in_t x);
    adis_out_t  r;
    int         p;
    int         vlen;
    int         v;
    logic [7:0] b;
    logic [7:0] t;
    b = x.ad_byte;
    p = pos;
    r = '0;
    r.skeleton_byte = b;
    if (p == 0) company_seen = x.company_code;

    if (p >= MaxPayloadDef) begin
      rejected = 1'b1;
    end else if (!stopped && !rejected) begin
      if (p == el_end) begin
        // length byte: open an element, or stop on zero
        if (!x.is_last_byte) begin
          if (b == 8'h00) begin
            stopped = 1'b1;
          end else begin
            el_start = 6'(p);
            el_end = 9'(p + 1 + b);
            el_type = '0;
            prefix_seen = '0;
          end
        end
      end else begin
        vlen = int'(el_end) - int'(el_start) - 2;
        if (p == int'(el_start) + 1) begin
          // type byte
          el_type = b;
          if (b == TypeNameShort || b == TypeNameFull) begin
            noff_seen = 5'(int'(el_start) + 2);
            nlen_seen = 5'(vlen);
          end else if ((b == TypeMfrData || b == TypeSvcData16) && vlen < 2) begin
            rejected = 1'b1;
          end
        end else begin
          // value byte
          v = p - int'(el_start) - 2;
          t = el_type;
          if (t == TypeNameShort || t == TypeNameFull) begin
            r.skeleton_byte = 8'h00;
          end else if (t == TypeMfrData) begin
            case (v)
              0: if (b == Prefix0) prefix_seen[0] = 1'b1;
              1: if (b == Prefix1) prefix_seen[1] = 1'b1;
              2: begin
                if (b == Prefix2) prefix_seen[2] = 1'b1;
                mask_seen[p] = 1'b1;
              end
              3: begin
                if (b == Prefix3) prefix_seen[3] = 1'b1;
                if (vlen >= 4 && prefix_seen == 4'hF) mask_seen[p - 1] = 1'b0;
                else mask_seen[p] = 1'b1;
              end
              default: mask_seen[p] = 1'b1;
            endcase
          end else if (t == TypeSvcData16) begin
            if (v == 0) uuid_seen[7:0] = b;
            else if (v == 1) uuid_seen[15:8] = b;
            else mask_seen[p] = 1'b1;
          end else if (!(t inside {TypeFlags, TypeUuid16Inc, TypeUuid16Cmp,
                                   TypeTxPower, TypeAppearance})) begin
            mask_seen[p] = 1'b1;
          end
        end
      end
    end

    if (x.is_last_byte) begin
      if (!rejected && !stopped && int'(el_end) > p + 1) rejected = 1'b1;
      r.end_of_payload = 1'b1;
      if (!rejected) begin
        r.accepted = 1'b1;
        r.random_mask = mask_seen;
        r.name_offset = noff_seen;
        r.name_length = nlen_seen;
        r.service_uuid = uuid_seen;
        if (company_seen == CompanyRef) r.family_code = FamCompany;
        else if (uuid_seen == UuidRefA) r.family_code = FamUuidA;
        else if (uuid_seen == UuidRefB) r.family_code = FamUuidB;
        else r.family_code = FamOther;
      end
      clear_walker();
    end else if (pos < 6'd63) begin
      pos = 6'(p + 1);
    end
    return r;
  endfunction

  // Offer one beat after a random gap, hold it until taken, then predict.
  task automatic send_beat(input adis_in_t beat, input bit brisk, input bit typed,
                           input adis_out_t want);
    int        gap;
    adis_out_t pred;
    gap = brisk ? 0 : $urandom_range(0, MaxGap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= beat;
    do @(posedge clk); while (!in_ready);
    pred = walk_byte(beat);
    pending_results.push_back(typed ? want : pred);
    n_sent++;
    if (pred.end_of_payload) begin
      n_payloads++;
      if (pred.accepted) n_accepted++;
    end
  endtask

  task automatic send_frame(input bit brisk);
    adis_in_t  beat;
    adis_out_t none;
    none = '0;
    foreach (frame[i]) begin
      beat.ad_byte = frame[i];
      beat.is_last_byte = (i == frame.size() - 1);
      beat.company_code = (i == 0 && $urandom_range(0, 3) == 0) ? CompanyRef
                                                                  : 16'($urandom);
      send_beat(beat, brisk, 1'b0, none);
    end
  endtask

  // Fill the frame with well-formed elements of random types and contents.
  task automatic build_wellformed();
    int         limit;
    int         room;
    int         len;
    int         i;
    int         pick;
    bit         beacon;
    logic [7:0] etype;
    logic [7:0] vb;
    logic [7:0] pfx [4];
    pfx = '{Prefix0, Prefix1, Prefix2, Prefix3};
    frame.delete();
    limit = ($urandom_range(0, 3) == 0) ? MaxPayloadDef : $urandom_range(2, MaxPayloadDef);
    while (frame.size() + 2 <= limit) begin
      room = limit - frame.size() - 1;
      pick = $urandom_range(0, 10);
      case (pick)
        0: etype = TypeFlags;
        1: etype = TypeUuid16Inc;
        2: etype = TypeUuid16Cmp;
        3: etype = TypeTxPower;
        4: etype = TypeAppearance;
        5: etype = TypeNameShort;
        6: etype = TypeNameFull;
        7: etype = TypeSvcData16;
        8, 9: etype = TypeMfrData;
        default: etype = 8'($urandom);
      endcase
      if ((etype == TypeMfrData || etype == TypeSvcData16) && room < 3) etype = TypeFlags;
      len = $urandom_range((etype == TypeMfrData || etype == TypeSvcData16) ? 3 : 1,
                           (room > 8 && $urandom_range(0, 2) != 0) ? 8 : room);
      frame.push_back(8'(len));
      frame.push_back(etype);
      beacon = $urandom_range(0, 1);
      pick = $urandom_range(0, 2);
      for (i = 0; i < len - 1; i++) begin
        vb = 8'($urandom);
        if (etype == TypeMfrData && beacon && i < 4) begin
          vb = pfx[i];
          if ($urandom_range(0, 9) == 0) vb = vb ^ 8'($urandom_range(1, 255));
        end else if (etype == TypeSvcData16 && i < 2 && pick != 2) begin
          vb = (pick == 0) ? (i == 0 ? UuidRefA[7:0] : UuidRefA[15:8])
                           : (i == 0 ? UuidRefB[7:0] : UuidRefB[15:8]);
        end
        frame.push_back(vb);
      end
    end
    // now and then end the walk early with a zero length and trailing junk
    if ($urandom_range(0, 5) == 0 && frame.size() < limit) begin
      frame.push_back(8'h00);
      while (frame.size() < limit) frame.push_back(8'($urandom));
    end
  endtask

  // Stimulus: directed table, then random payloads
  initial begin : stimulus
    int        i;
    int        style;
    int        target;
    int        brisk_left;
    bit        brisk;
    bit        hold_done;
    bit        pause_done;
    adis_in_t  beat;
    adis_out_t want;
    brisk_left = 0;
    hold_done = 1'b0;
    pause_done = 1'b0;
    clear_walker();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < NRows; i++) begin
      beat.ad_byte = DirRows[i].b;
      beat.is_last_byte = DirRows[i].last;
      beat.company_code = DirRows[i].co;
      want = '0;
      want.skeleton_byte = DirRows[i].b;
      want.end_of_payload = 1'b1;
      want.accepted = DirRows[i].acc;
      want.family_code = DirRows[i].fam;
      send_beat(beat, 1'b0, DirRows[i].typed, want);
    end

    while (n_sent < ItemTarget) begin
      brisk = ($urandom_range(0, 4) == 0);
      // stall the output for a long stretch while input keeps coming
      if (!hold_done && n_sent >= HoldAt) begin
        hold_done = 1'b1;
        rx_hold = 1'b1;
        brisk_left = 4;
      end
      if (brisk_left > 0) begin
        brisk = 1'b1;
        brisk_left--;
      end
      // let the output side drain completely once
      if (!pause_done && n_sent >= PauseAt) begin
        pause_done = 1'b1;
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
      end

      style = $urandom_range(0, 19);
      if (style < 14) begin
        build_wellformed();
      end else if (style < 16) begin
        // truncate so the last element overruns
        build_wellformed();
        target = $urandom_range(1, 3);
        while (target > 0 && frame.size() > 1) begin
          void'(frame.pop_back());
          target--;
        end
      end else if (style < 17) begin
        // pad past the payload limit
        build_wellformed();
        target = $urandom_range(MaxPayloadDef + 1, 70);
        while (frame.size() < target) frame.push_back(8'($urandom));
      end else begin
        target = ($urandom_range(0, 9) == 0) ? $urandom_range(MaxPayloadDef + 1, 70)
                                             : $urandom_range(1, 40);
        frame.delete();
        repeat (target) frame.push_back(8'($urandom));
      end
      send_frame(brisk);
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    $display("Sent %0d bytes in %0d payloads (%0d accepted, %0d rejected).",
             n_sent, n_payloads, n_accepted, n_payloads - n_accepted);
    $display("Checked %0d result beats, %0d mismatches.", n_checked, errors);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Output side: random stalls, quiet runs, one long hold; check every beat
  initial begin : result_check
    int        stall;
    int        quiet_left;
    adis_out_t want;
    adis_out_t got;
    quiet_left = 0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (rx_hold) begin
        stall = HoldCycles;
        rx_hold = 1'b0;
      end else if (quiet_left > 0) begin
        stall = 0;
        quiet_left--;
      end else begin
        stall = $urandom_range(0, MaxGap);
        if ($urandom_range(0, 39) == 0) quiet_left = 30;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got = out_data;
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: %p", got);
        errors++;
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (got.skeleton_byte !== want.skeleton_byte) begin
          $error("skeleton_byte: expected %0h, got %0h", want.skeleton_byte, got.skeleton_byte);
          errors++;
        end
        if (got.end_of_payload !== want.end_of_payload) begin
          $error("end_of_payload: expected %0h, got %0h",
                 want.end_of_payload, got.end_of_payload);
          errors++;
        end
        if (got.accepted !== want.accepted) begin
          $error("accepted: expected %0h, got %0h", want.accepted, got.accepted);
          errors++;
        end
        if (got.random_mask !== want.random_mask) begin
          $error("random_mask: expected %0h, got %0h", want.random_mask, got.random_mask);
          errors++;
        end
        if (got.name_offset !== want.name_offset) begin
          $error("name_offset: expected %0h, got %0h", want.name_offset, got.name_offset);
          errors++;
        end
        if (got.name_length !== want.name_length) begin
          $error("name_length: expected %0h, got %0h", want.name_length, got.name_length);
          errors++;
        end
        if (got.service_uuid !== want.service_uuid) begin
          $error("service_uuid: expected %0h, got %0h", want.service_uuid, got.service_uuid);
          errors++;
        end
        if (got.family_code !== want.family_code) begin
          $error("family_code: expected %0h, got %0h", want.family_code, got.family_code);
          errors++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
